@@ src/matrix_multiply_4x4_assert.svh @@
// assertion macros used by the matrix multiplier top level
`ifndef MATRIX_MULTIPLY_4X4_ASSERT_SVH
`define MATRIX_MULTIPLY_4X4_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define MM4_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mm4 same-cycle check failed");

// next-cycle implication, sampled on clk, off during reset
`define MM4_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mm4 next-cycle check failed");

`endif

@@ src/mm4_pkg.sv @@
// types and constants of the 4x4 fixed-point matrix multiplier
package mm4_pkg;

  localparam int DIM    = 4;
  localparam int IDX_W  = 2;
  localparam int ELEM_W = 32;
  localparam int FRAC_W = 16;
  localparam int PROD_W = 2 * ELEM_W;
  localparam int ACC_W  = PROD_W + 2;

  typedef logic signed [ELEM_W-1:0] mm4_elem_t;

  typedef struct packed {
    logic [IDX_W-1:0] row_index;
    mm4_elem_t        a_col0;
    mm4_elem_t        a_col1;
    mm4_elem_t        a_col2;
    mm4_elem_t        a_col3;
    mm4_elem_t        b_col0;
    mm4_elem_t        b_col1;
    mm4_elem_t        b_col2;
    mm4_elem_t        b_col3;
    logic             load_done;
  } mm4_in_req_t;

  typedef struct packed {
    logic [IDX_W-1:0] out_row;
    mm4_elem_t        c_col0;
    mm4_elem_t        c_col1;
    mm4_elem_t        c_col2;
    mm4_elem_t        c_col3;
    logic             final_row;
  } mm4_out_req_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_ISSUE,
    ST_WAIT
  } mm4_state_t;

  // one multiply step issued to every lane
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mm4_lane_ctl_t;

  // row hand-off into the output register
  typedef struct packed {
    logic             load;
    logic [IDX_W-1:0] row;
    logic             final_row;
  } mm4_merge_ctl_t;

endpackage

@@ src/mm4_store.sv @@
// row storage for matrices a and b, cleared at reset
module mm4_store (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  mm4_pkg::mm4_in_req_t          wr_req,
  input  logic [mm4_pkg::IDX_W-1:0]     rd_row,
  input  logic [mm4_pkg::IDX_W-1:0]     rd_col,
  output mm4_pkg::mm4_elem_t            a_elem,
  output mm4_pkg::mm4_elem_t            b_row [mm4_pkg::DIM]
);

  mm4_pkg::mm4_elem_t a_r [mm4_pkg::DIM][mm4_pkg::DIM];
  mm4_pkg::mm4_elem_t b_r [mm4_pkg::DIM][mm4_pkg::DIM];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < mm4_pkg::DIM; r++) begin
        for (int c = 0; c < mm4_pkg::DIM; c++) begin
          a_r[r][c] <= '0;
          b_r[r][c] <= '0;
        end
      end
    end else if (wr_en) begin
      a_r[wr_req.row_index][0] <= wr_req.a_col0;
      a_r[wr_req.row_index][1] <= wr_req.a_col1;
      a_r[wr_req.row_index][2] <= wr_req.a_col2;
      a_r[wr_req.row_index][3] <= wr_req.a_col3;
      b_r[wr_req.row_index][0] <= wr_req.b_col0;
      b_r[wr_req.row_index][1] <= wr_req.b_col1;
      b_r[wr_req.row_index][2] <= wr_req.b_col2;
      b_r[wr_req.row_index][3] <= wr_req.b_col3;
    end
  end

  // a[i][k] broadcast to all lanes, row k of b split across lanes
  assign a_elem = a_r[rd_row][rd_col];

  always_comb begin
    for (int c = 0; c < mm4_pkg::DIM; c++) begin
      b_row[c] = b_r[rd_col][c];
    end
  end

endmodule

@@ src/mm4_lane.sv @@
// one column lane: registered multiply, then full-precision accumulate
module mm4_lane (
  input  logic                              clk,
  input  logic                              rst_n,
  input  mm4_pkg::mm4_lane_ctl_t            ctl,
  input  mm4_pkg::mm4_elem_t                a_in,
  input  mm4_pkg::mm4_elem_t                b_in,
  output logic signed [mm4_pkg::ACC_W-1:0]  acc,
  output logic                              done
);

  logic signed [mm4_pkg::PROD_W-1:0] prod_r;
  logic signed [mm4_pkg::PROD_W-1:0] prod_nxt;
  logic                              p_valid_r;
  logic                              p_first_r;
  logic                              p_last_r;
  logic signed [mm4_pkg::ACC_W-1:0]  acc_r;
  logic signed [mm4_pkg::ACC_W-1:0]  acc_nxt;
  logic signed [mm4_pkg::ACC_W-1:0]  prod_ext;
  logic                              done_r;

  assign prod_nxt = a_in * b_in;
  assign prod_ext = {{(mm4_pkg::ACC_W - mm4_pkg::PROD_W){prod_r[mm4_pkg::PROD_W-1]}}, prod_r};
  assign acc_nxt  = p_first_r ? prod_ext : acc_r + prod_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
      done_r    <= 1'b0;
    end else begin
      p_valid_r <= ctl.valid;
      done_r    <= p_valid_r && p_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.valid) begin
      prod_r    <= prod_nxt;
      p_first_r <= ctl.first;
      p_last_r  <= ctl.last;
    end
    if (p_valid_r) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc  = acc_r;
  assign done = done_r;

endmodule

@@ src/mm4_merge.sv @@
// merges lane sums: shift by the fraction width, saturate, hold for the receiver
module mm4_merge (
  input  logic                              clk,
  input  logic                              rst_n,
  input  mm4_pkg::mm4_merge_ctl_t           ctl,
  input  logic signed [mm4_pkg::ACC_W-1:0]  acc [mm4_pkg::DIM],
  output logic                              slot_free,
  output logic                              out_valid,
  input  logic                              out_stall,
  output mm4_pkg::mm4_out_req_t             out_data
);

  localparam int TOP_W = mm4_pkg::ACC_W - mm4_pkg::FRAC_W - mm4_pkg::ELEM_W + 1;
  localparam int MSB_L = mm4_pkg::FRAC_W + mm4_pkg::ELEM_W - 1;

  function automatic mm4_pkg::mm4_elem_t sat_shift(
    input logic signed [mm4_pkg::ACC_W-1:0] v
  );
    logic [TOP_W-1:0] upper;
    upper = v[mm4_pkg::ACC_W-1:MSB_L];
    priority if (upper == '0 || upper == '1) begin
      sat_shift = v[MSB_L:mm4_pkg::FRAC_W];
    end else if (v[mm4_pkg::ACC_W-1]) begin
      sat_shift = {1'b1, {(mm4_pkg::ELEM_W-1){1'b0}}};
    end else begin
      sat_shift = {1'b0, {(mm4_pkg::ELEM_W-1){1'b1}}};
    end
  endfunction

  logic                  out_valid_r;
  mm4_pkg::mm4_out_req_t out_data_r;
  mm4_pkg::mm4_out_req_t out_data_nxt;

  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    out_data_nxt.out_row   = ctl.row;
    out_data_nxt.c_col0    = sat_shift(acc[0]);
    out_data_nxt.c_col1    = sat_shift(acc[1]);
    out_data_nxt.c_col2    = sat_shift(acc[2]);
    out_data_nxt.c_col3    = sat_shift(acc[3]);
    out_data_nxt.final_row = ctl.final_row;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ src/matrix_multiply_4x4.sv @@
// top level of the 4x4 signed q16.16 matrix multiplier
//
// usage:
//   input channel (in_valid / in_stall / in_data): each request writes one row of a
//   and the same row of b. a request with load_done set writes its row and then
//   starts the product c = a * b over whatever the stores hold.
//   result channel (out_valid / out_stall / out_data): four requests per product,
//   rows 0..3 in order, final_row set on row 3.
//   each row's four k terms are issued to the lanes in turn, then pass the product,
//   accumulate and done registers and the row-ready flag into the output register;
//   the next row is issued once that row has entered it. rows without load_done are
//   taken without stalling. each of the four column lanes has one 32x32 multiplier that
//   walks the four k terms of a row, plus product and accumulate registers.
//   in_stall is high after the load_done request is taken until the last row has entered
//   the output register.
//   reset clears both stores to zero and drops out_valid.
//   when the receiver stalls, the finished row waits in the output register and
//   the next row is computed but not handed over until that slot frees up.
`include "matrix_multiply_4x4_assert.svh"

module matrix_multiply_4x4 (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  mm4_pkg::mm4_in_req_t  in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output mm4_pkg::mm4_out_req_t out_data
);

  // sequencer state
  mm4_pkg::mm4_state_t           state_r;
  mm4_pkg::mm4_state_t           state_nxt;
  logic [mm4_pkg::IDX_W-1:0]     row_cnt_r;   // product row i
  logic [mm4_pkg::IDX_W-1:0]     k_cnt_r;     // inner term k
  logic                          row_ready_r; // lane sums complete for row i

  // sequencer outputs
  logic                          wr_en;
  logic                          start;
  logic                          emit;
  mm4_pkg::mm4_lane_ctl_t        lane_ctl;
  mm4_pkg::mm4_merge_ctl_t       merge_ctl;

  // datapath
  mm4_pkg::mm4_elem_t            a_elem;
  mm4_pkg::mm4_elem_t            b_row [mm4_pkg::DIM];
  logic signed [mm4_pkg::ACC_W-1:0] lane_acc [mm4_pkg::DIM];
  logic [mm4_pkg::DIM-1:0]       lane_done;
  logic                          slot_free;
  logic                          last_k;
  logic                          last_row;

  localparam logic [mm4_pkg::IDX_W-1:0] LAST_IDX = mm4_pkg::IDX_W'(mm4_pkg::DIM - 1);

  assign last_k   = (k_cnt_r == LAST_IDX);
  assign last_row = (row_cnt_r == LAST_IDX);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mm4_pkg::ST_LOAD: begin
        if (in_valid && in_data.load_done) begin
          state_nxt = mm4_pkg::ST_ISSUE;
        end
      end
      mm4_pkg::ST_ISSUE: begin
        if (last_k) begin
          state_nxt = mm4_pkg::ST_WAIT;
        end
      end
      mm4_pkg::ST_WAIT: begin
        if (row_ready_r && slot_free) begin
          state_nxt = last_row ? mm4_pkg::ST_LOAD : mm4_pkg::ST_ISSUE;
        end
      end
      default: begin
        state_nxt = mm4_pkg::ST_LOAD;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall  = 1'b1;
    wr_en     = 1'b0;
    start     = 1'b0;
    emit      = 1'b0;
    lane_ctl  = '0;
    unique case (state_r)
      mm4_pkg::ST_LOAD: begin
        in_stall = 1'b0;
        wr_en    = in_valid;
        start    = in_valid && in_data.load_done;
      end
      mm4_pkg::ST_ISSUE: begin
        lane_ctl.valid = 1'b1;
        lane_ctl.first = (k_cnt_r == '0);
        lane_ctl.last  = last_k;
      end
      mm4_pkg::ST_WAIT: begin
        emit = row_ready_r && slot_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
    merge_ctl.load      = emit;
    merge_ctl.row       = row_cnt_r;
    merge_ctl.final_row = last_row;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mm4_pkg::ST_LOAD;
      row_cnt_r   <= '0;
      k_cnt_r     <= '0;
      row_ready_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // k wraps back to zero after the last term of a row
      if (start) begin
        k_cnt_r <= '0;
      end else if (lane_ctl.valid) begin
        k_cnt_r <= k_cnt_r + 1'b1;
      end
      if (start) begin
        row_cnt_r <= '0;
      end else if (emit) begin
        row_cnt_r <= row_cnt_r + 1'b1;
      end
      if (emit) begin
        row_ready_r <= 1'b0;
      end else if (&lane_done) begin
        row_ready_r <= 1'b1;
      end
    end
  end

  mm4_store u_store (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (wr_en),
    .wr_req (in_data),
    .rd_row (row_cnt_r),
    .rd_col (k_cnt_r),
    .a_elem (a_elem),
    .b_row  (b_row)
  );

  // one lane per result column
  for (genvar j = 0; j < mm4_pkg::DIM; j++) begin : g_lane
    mm4_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (lane_ctl),
      .a_in  (a_elem),
      .b_in  (b_row[j]),
      .acc   (lane_acc[j]),
      .done  (lane_done[j])
    );
  end

  mm4_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (merge_ctl),
    .acc       (lane_acc),
    .slot_free (slot_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // lane sums only finish while the sequencer waits for them
  `MM4_ASSERT_NOW(a_done_in_wait, |lane_done, state_r == mm4_pkg::ST_WAIT)
  // all lanes step in lock-step
  `MM4_ASSERT_NOW(a_lanes_agree, |lane_done, &lane_done)
  // a row is issued in exactly four terms and k is back at zero afterwards
  `MM4_ASSERT_NEXT(a_issue_wraps, state_r == mm4_pkg::ST_ISSUE && last_k,
                   state_r == mm4_pkg::ST_WAIT && k_cnt_r == '0)
  // handing over the last row returns to loading
  `MM4_ASSERT_NEXT(a_last_row_ends, emit && last_row, state_r == mm4_pkg::ST_LOAD)

endmodule
